### rtl/uart_frame_receiver_crc8_core_assert.svh
// Assertion macros for the UART frame receiver core.
// Needs a clock named clk and a synchronous reset named rst in the using scope.
`ifndef UART_FRAME_RECEIVER_CRC8_CORE_ASSERT_SVH
`define UART_FRAME_RECEIVER_CRC8_CORE_ASSERT_SVH

// Same-cycle implication
`define URFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define URFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/urfc_pkg.sv
// Shared types, codes and the CRC-8/MAXIM byte update for the frame receiver.
// No dependencies.
package urfc_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_HEAD_DEVICE  = 2'd0,
    REG_HEAD_FORWARD = 2'd1,
    REG_BYTE_TIMEOUT = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SEQ  = 3'd1,
    PH_ID   = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  localparam logic       FUNC_BYTE = 1'b0;
  localparam logic       FUNC_TICK = 1'b1;

  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
  localparam logic [7:0] CRC_START     = 8'h00;

  localparam logic [7:0]  HEAD_DEVICE_RST  = 8'd170;
  localparam logic [7:0]  HEAD_FORWARD_RST = 8'd85;
  localparam logic [15:0] BYTE_TIMEOUT_RST = 16'd20;

  typedef struct packed {
    logic [7:0]  head_device;
    logic [7:0]  head_forward;
    logic [15:0] byte_timeout_ticks;
  } cfg_t;

  // Reflected CRC-8, one byte, eight shift steps
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/urfc_cfg_regs.sv
// APB register file for the frame receiver: head values and byte timeout.
// Depends on urfc_pkg.
module urfc_cfg_regs
  import urfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_device        <= HEAD_DEVICE_RST;
      cfg.head_forward       <= HEAD_FORWARD_RST;
      cfg.byte_timeout_ticks <= BYTE_TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HEAD_DEVICE:  cfg.head_device        <= pwdata[7:0];
        REG_HEAD_FORWARD: cfg.head_forward       <= pwdata[7:0];
        REG_BYTE_TIMEOUT: cfg.byte_timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEAD_DEVICE:  prdata = {24'd0, cfg.head_device};
      REG_HEAD_FORWARD: prdata = {24'd0, cfg.head_forward};
      REG_BYTE_TIMEOUT: prdata = {16'd0, cfg.byte_timeout_ticks};
      default:          prdata = '0;
    endcase
  end

endmodule

### rtl/uart_frame_receiver_crc8_core.sv
// UART frame receiver with CRC-8/MAXIM check: top level.
// A request is first captured in the input register; its result, if any, is then registered in
// the result register, where result_valid rises.
// Throughput: one request per cycle; a result held by result_ready low stalls the input.
// Reset (rst, synchronous): idle phase, empty registers, timer and sequences zero.
// Depends on urfc_pkg, urfc_cfg_regs and uart_frame_receiver_crc8_core_assert.svh.
`include "uart_frame_receiver_crc8_core_assert.svh"

module uart_frame_receiver_crc8_core
  import urfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  func,
  input  logic [7:0]            rx_byte,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [1:0]            kind,
  output logic [7:0]            data_byte,
  output logic [7:0]            data_index,
  output logic [7:0]            msg_seq,
  output logic [7:0]            msg_id,
  output logic [7:0]            data_len,
  output logic                  via_forward_head,
  output logic                  crc_ok,
  output logic                  seq_repeat
);

  cfg_t cfg;

  urfc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register
  logic       inq_valid;
  logic       inq_func;
  logic [7:0] inq_byte;

  // Frame state
  phase_t      phase, phase_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [7:0]  bytes_remaining, bytes_remaining_next;
  logic [7:0]  payload_index, payload_index_next;
  logic [7:0]  frame_seq, frame_seq_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [7:0]  frame_len, frame_len_next;
  logic        forward_flag, forward_flag_next;
  logic [7:0]  accepted_seq, accepted_seq_next;
  logic [15:0] timeout_timer, timeout_timer_next;

  // Result produced this cycle
  logic       res_load;
  kind_t      res_kind;
  logic [7:0] res_byte;
  logic [7:0] res_index;
  logic       res_ok;
  logic       res_rep;

  logic        proc_fire;
  logic [15:0] timer_dec;
  logic [7:0]  crc_upd;

  assign proc_fire  = inq_valid && (!result_valid || result_ready);
  assign item_ready = !inq_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (item_ready) begin
      inq_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      inq_func <= func;
      inq_byte <= rx_byte;
    end
  end

  assign timer_dec = (timeout_timer != 16'd0) ? timeout_timer - 16'd1 : timeout_timer;
  assign crc_upd   = crc8_step((phase == PH_IDLE) ? CRC_START : running_crc, inq_byte);

  always_comb begin
    phase_next           = phase;
    running_crc_next     = running_crc;
    bytes_remaining_next = bytes_remaining;
    payload_index_next   = payload_index;
    frame_seq_next       = frame_seq;
    frame_id_next        = frame_id;
    frame_len_next       = frame_len;
    forward_flag_next    = forward_flag;
    accepted_seq_next    = accepted_seq;
    timeout_timer_next   = timeout_timer;
    res_load             = 1'b0;
    res_kind             = KIND_DATA;
    res_byte             = 8'd0;
    res_index            = 8'd0;
    res_ok               = 1'b0;
    res_rep              = 1'b0;

    if (inq_func == FUNC_TICK) begin
      timeout_timer_next = timer_dec;
      if (phase != PH_IDLE && timer_dec == 16'd0) begin
        phase_next = PH_IDLE;
        res_load   = 1'b1;
        res_kind   = KIND_ABORT;
      end
    end else begin
      timeout_timer_next = cfg.byte_timeout_ticks;
      unique case (phase)
        PH_IDLE: begin
          if (inq_byte == cfg.head_device || inq_byte == cfg.head_forward) begin
            forward_flag_next = (inq_byte != cfg.head_device);
            frame_seq_next    = 8'd0;
            frame_id_next     = 8'd0;
            frame_len_next    = 8'd0;
            running_crc_next  = crc_upd;
            phase_next        = PH_SEQ;
          end
        end
        PH_SEQ: begin
          frame_seq_next   = inq_byte;
          running_crc_next = crc_upd;
          phase_next       = PH_ID;
        end
        PH_ID: begin
          frame_id_next    = inq_byte;
          running_crc_next = crc_upd;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          frame_len_next       = inq_byte;
          bytes_remaining_next = inq_byte;
          payload_index_next   = 8'd0;
          running_crc_next     = crc_upd;
          phase_next           = PH_DATA;
        end
        PH_DATA: begin
          res_load = 1'b1;
          if (bytes_remaining != 8'd0) begin
            bytes_remaining_next = bytes_remaining - 8'd1;
            payload_index_next   = payload_index + 8'd1;
            running_crc_next     = crc_upd;
            res_kind             = KIND_DATA;
            res_byte             = inq_byte;
            res_index            = payload_index;
          end else begin
            // CRC byte: close the frame, update the accepted sequence on a match
            phase_next = PH_IDLE;
            res_kind   = KIND_END;
            res_ok     = (running_crc == inq_byte);
            if (res_ok) begin
              accepted_seq_next = frame_seq;
              res_rep           = (accepted_seq == frame_seq);
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      running_crc     <= 8'd0;
      bytes_remaining <= 8'd0;
      payload_index   <= 8'd0;
      frame_seq       <= 8'd0;
      frame_id        <= 8'd0;
      frame_len       <= 8'd0;
      forward_flag    <= 1'b0;
      accepted_seq    <= 8'd0;
      timeout_timer   <= 16'd0;
    end else if (proc_fire) begin
      phase           <= phase_next;
      running_crc     <= running_crc_next;
      bytes_remaining <= bytes_remaining_next;
      payload_index   <= payload_index_next;
      frame_seq       <= frame_seq_next;
      frame_id        <= frame_id_next;
      frame_len       <= frame_len_next;
      forward_flag    <= forward_flag_next;
      accepted_seq    <= accepted_seq_next;
      timeout_timer   <= timeout_timer_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (proc_fire) begin
      result_valid <= res_load;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res_load) begin
      kind             <= res_kind;
      data_byte        <= res_byte;
      data_index       <= res_index;
      msg_seq          <= frame_seq;
      msg_id           <= frame_id;
      data_len         <= frame_len;
      via_forward_head <= forward_flag;
      crc_ok           <= res_ok;
      seq_repeat       <= res_rep;
    end
  end

  `URFC_ASSERT_IMP(a_ready_when_slot_free, !result_valid, item_ready, "input stalled with empty result slot")
  `URFC_ASSERT_NXT(a_idle_after_end, proc_fire && res_load && res_kind != KIND_DATA, phase == PH_IDLE, "frame not closed after end or abort")
  `URFC_ASSERT_IMP(a_repeat_needs_ok, result_valid && seq_repeat, crc_ok && kind == KIND_END, "sequence repeat without good CRC")
  `URFC_ASSERT_IMP(a_data_needs_phase, proc_fire && res_load && res_kind == KIND_DATA, phase == PH_DATA, "payload result outside data phase")

endmodule

### dv/uart_frame_receiver_crc8_core_tb.sv
// Self-checking bench for the UART frame receiver core with CRC-8/MAXIM check.
// Needs urfc_pkg and uart_frame_receiver_crc8_core; drives APB, request and result
// channels with random idling and predicts every result in-line.
`timescale 1ns / 100ps

module uart_frame_receiver_crc8_core_tb;
  import urfc_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic       func;
    logic [7:0] rx;
  } rx_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [7:0] msg_seq;
    logic [7:0] msg_id;
    logic [7:0] data_len;
    logic       via_forward_head;
    logic       crc_ok;
    logic       seq_repeat;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  logic                  func = FUNC_BYTE;
  logic [7:0]            rx_byte = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic [1:0]            kind;
  logic [7:0]            data_byte;
  logic [7:0]            data_index;
  logic [7:0]            msg_seq;
  logic [7:0]            msg_id;
  logic [7:0]            data_len;
  logic                  via_forward_head;
  logic                  crc_ok;
  logic                  seq_repeat;

  uart_frame_receiver_crc8_core dut (.*);

  always #5 clk = ~clk;

  // Predictor state and register copy
  cfg_t       pred_cfg;
  phase_t     rx_phase;
  logic [7:0] rx_crc, rx_left, rx_idx;
  logic [7:0] hdr_seq, hdr_id, hdr_len;
  logic       hdr_fwd;
  logic [7:0] seq_last, seq_prior;
  logic [15:0] gap_timer;

  frame_result_t frame_expect_q[$];
  rx_item_t      rx_pending[$];

  int unsigned issued_cnt = 0, accepted_cnt = 0, results_got = 0, seen_results = 0;
  int unsigned mismatch_cnt = 0, frame_items = 0, idle_cycles = 0;
  int unsigned n_data = 0, n_end = 0, n_good = 0, n_abort = 0, n_settings = 1;
  int          send_gap = 0, send_burst = 0, recv_stall = 0, recv_burst = 0;
  logic [7:0]  stim_last_seq = '0;
  rx_item_t      nxt;
  frame_result_t pred, act, exp_r;

  function automatic logic [7:0] crc_maxim_byte(input logic [7:0] acc, input logic [7:0] din);
    logic [7:0] r;
    r = acc ^ din;
    repeat (8) r = {1'b0, r[7:1]} ^ (r[0] ? CRC_POLY_REFL : 8'h00);
    return r;
  endfunction

  // Advance the predictor by one request; returns 1 when a result is due
  function automatic bit frame_predict(input logic f, input logic [7:0] b,
                                       output frame_result_t r);
    bit hit;
    hit = 1'b0;
    r   = '0;
    if (f == FUNC_TICK) begin
      if (gap_timer != 0) gap_timer = gap_timer - 16'd1;
      if (rx_phase != PH_IDLE && gap_timer == 0) begin
        rx_phase = PH_IDLE;
        r.kind   = KIND_ABORT;
        hit      = 1'b1;
      end
    end else begin
      gap_timer = pred_cfg.byte_timeout_ticks;
      case (rx_phase)
        PH_IDLE: begin
          if (b == pred_cfg.head_device || b == pred_cfg.head_forward) begin
            hdr_fwd  = (b != pred_cfg.head_device);
            hdr_seq  = '0;
            hdr_id   = '0;
            hdr_len  = '0;
            rx_crc   = crc_maxim_byte(CRC_START, b);
            rx_phase = PH_SEQ;
          end
        end
        PH_SEQ: begin
          hdr_seq  = b;
          rx_crc   = crc_maxim_byte(rx_crc, b);
          rx_phase = PH_ID;
        end
        PH_ID: begin
          hdr_id   = b;
          rx_crc   = crc_maxim_byte(rx_crc, b);
          rx_phase = PH_LEN;
        end
        PH_LEN: begin
          hdr_len  = b;
          rx_left  = b;
          rx_idx   = '0;
          rx_crc   = crc_maxim_byte(rx_crc, b);
          rx_phase = PH_DATA;
        end
        PH_DATA: begin
          hit = 1'b1;
          if (rx_left != 0) begin
            r.kind       = KIND_DATA;
            r.data_byte  = b;
            r.data_index = rx_idx;
            rx_left      = rx_left - 8'd1;
            rx_idx       = rx_idx + 8'd1;
            rx_crc       = crc_maxim_byte(rx_crc, b);
          end else begin
            r.kind   = KIND_END;
            r.crc_ok = (rx_crc == b);
            rx_phase = PH_IDLE;
            // shift the accepted sequence history only on a good check
            if (r.crc_ok) begin
              seq_prior    = seq_last;
              seq_last     = hdr_seq;
              r.seq_repeat = (seq_prior == seq_last);
            end
          end
        end
        default: rx_phase = PH_IDLE;
      endcase
    end
    if (hit) begin
      r.msg_seq          = hdr_seq;
      r.msg_id           = hdr_id;
      r.data_len         = hdr_len;
      r.via_forward_head = hdr_fwd;
    end
    return hit;
  endfunction

  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) burst = $urandom_range(8, 40);
    return $urandom_range(0, 7);
  endfunction

  task automatic report_mismatch(input string what, input frame_result_t e,
                                 input frame_result_t a);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] %s: exp kind=%0d byte=%h idx=%0d seq=%h id=%h len=%0d fwd=%b ok=%b rep=%b",
               $time, what, e.kind, e.data_byte, e.data_index, e.msg_seq, e.msg_id,
               e.data_len, e.via_forward_head, e.crc_ok, e.seq_repeat);
      $display("          got kind=%0d byte=%h idx=%0d seq=%h id=%h len=%0d fwd=%b ok=%b rep=%b",
               a.kind, a.data_byte, a.data_index, a.msg_seq, a.msg_id,
               a.data_len, a.via_forward_head, a.crc_ok, a.seq_repeat);
    end
  endtask

  // Driver: present requests with random gaps, stall results at random
  always @(negedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      result_ready <= 1'b0;
    end else begin
      if (!(item_valid && issued_cnt != accepted_cnt)) begin
        if (send_gap > 0) begin
          item_valid <= 1'b0;
          send_gap--;
        end else if (rx_pending.size() != 0) begin
          nxt        = rx_pending.pop_front();
          item_valid <= 1'b1;
          func       <= nxt.func;
          rx_byte    <= nxt.rx;
          issued_cnt++;
          send_gap = draw_gap(send_burst);
        end else begin
          item_valid <= 1'b0;
        end
      end
      if (seen_results != results_got) begin
        seen_results = results_got;
        recv_stall   = draw_gap(recv_burst);
      end
      if (recv_stall > 0) begin
        result_ready <= 1'b0;
        recv_stall--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Monitor: check results against the oldest expectation, then predict new requests
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      results_got++;
      act.kind             = kind_t'(kind);
      act.data_byte        = data_byte;
      act.data_index       = data_index;
      act.msg_seq          = msg_seq;
      act.msg_id           = msg_id;
      act.data_len         = data_len;
      act.via_forward_head = via_forward_head;
      act.crc_ok           = crc_ok;
      act.seq_repeat       = seq_repeat;
      case (act.kind)
        KIND_DATA:  n_data++;
        KIND_END:   begin n_end++; if (act.crc_ok) n_good++; end
        KIND_ABORT: n_abort++;
        default: ;
      endcase
      if (frame_expect_q.size() == 0) begin
        report_mismatch("unexpected result", '0, act);
      end else begin
        exp_r = frame_expect_q.pop_front();
        if (act !== exp_r) report_mismatch("result mismatch", exp_r, act);
      end
    end
    if (!rst && item_valid && item_ready) begin
      accepted_cnt++;
      if (frame_predict(func, rx_byte, pred)) frame_expect_q.push_back(pred);
    end
  end

  // Watchdog on cycles without any accepted request, result or register write
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no progress for %0d cycles, %0d results outstanding",
               idle_cycles, frame_expect_q.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_t r, input logic [APB_DATA_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_HEAD_DEVICE:  pred_cfg.head_device        = v[7:0];
      REG_HEAD_FORWARD: pred_cfg.head_forward       = v[7:0];
      REG_BYTE_TIMEOUT: pred_cfg.byte_timeout_ticks = v[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Every queued request counts towards the traffic budget
  task automatic push_byte(input logic [7:0] b);
    rx_pending.push_back('{func: FUNC_BYTE, rx: b});
    frame_items++;
  endtask

  task automatic push_tick();
    rx_pending.push_back('{func: FUNC_TICK, rx: 8'($urandom_range(0, 255))});
    frame_items++;
  endtask

  // Queue a whole frame; ticks between bytes stay below the timeout
  task automatic queue_frame(input logic [7:0] head, input logic [7:0] seq,
                             input logic [7:0] id, input logic [7:0] len,
                             input bit good, input int gap_ticks);
    logic [7:0] body[$];
    logic [7:0] c;
    body.push_back(head);
    body.push_back(seq);
    body.push_back(id);
    body.push_back(len);
    for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
    c = CRC_START;
    foreach (body[i]) c = crc_maxim_byte(c, body[i]);
    if (!good) c = c ^ 8'($urandom_range(1, 255));
    body.push_back(c);
    foreach (body[i]) begin
      push_byte(body[i]);
      if (i < body.size() - 1 && gap_ticks > 0 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, gap_ticks)) push_tick();
    end
  endtask

  task automatic queue_random_traffic(input int unsigned n);
    int unsigned target;
    int          sel, gap, tmo, k;
    logic [7:0]  hd, sq, ln;
    target = frame_items + n;
    while (frame_items < target) begin
      tmo = pred_cfg.byte_timeout_ticks;
      gap = (tmo <= 1) ? 0 : ((tmo - 1 > 6) ? 6 : tmo - 1);
      sel = $urandom_range(0, 99);
      hd  = $urandom_range(0, 1) ? pred_cfg.head_forward : pred_cfg.head_device;
      sq  = ($urandom_range(0, 4) == 0) ? stim_last_seq : 8'($urandom_range(0, 255));
      ln  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(9, 40)) : 8'($urandom_range(0, 8));
      if (sel < 72 || (sel < 84 && tmo > 40)) begin
        queue_frame(hd, sq, 8'($urandom_range(0, 255)), ln, $urandom_range(0, 7) != 0, gap);
        stim_last_seq = sq;
      end else if (sel < 84) begin
        // broken frame: head and a few bytes, then let the timer run out
        k = $urandom_range(0, 6);
        push_byte(hd);
        repeat (k) push_byte(8'($urandom_range(0, 255)));
        repeat ((tmo == 0) ? 1 : tmo) push_tick();
      end else if (sel < 92) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) push_tick();
      end
    end
  endtask

  task automatic wait_idle();
    while (rx_pending.size() != 0 || issued_cnt != accepted_cnt || frame_expect_q.size() != 0)
      @(posedge clk);
    // bytes and ticks that give no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    pred_cfg.head_device        = HEAD_DEVICE_RST;
    pred_cfg.head_forward       = HEAD_FORWARD_RST;
    pred_cfg.byte_timeout_ticks = BYTE_TIMEOUT_RST;
    rx_phase  = PH_IDLE;
    rx_crc    = '0;
    rx_left   = '0;
    rx_idx    = '0;
    hdr_seq   = '0;
    hdr_id    = '0;
    hdr_len   = '0;
    hdr_fwd   = 1'b0;
    seq_last  = '0;
    seq_prior = '0;
    gap_timer = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: idle tick and noise, first frame with sequence zero repeats,
    // forward head, bad check keeps the history, good repeat of the last sequence
    push_tick();
    push_byte(8'h00);
    queue_frame(HEAD_DEVICE_RST, 8'h00, 8'hFF, 8'd0, 1'b1, 0);
    queue_frame(HEAD_FORWARD_RST, 8'hFF, 8'h00, 8'd2, 1'b1, 0);
    queue_frame(HEAD_DEVICE_RST, 8'hFF, 8'h5A, 8'd1, 1'b0, 0);
    queue_frame(HEAD_DEVICE_RST, 8'hFF, 8'hA5, 8'd0, 1'b1, 0);
    queue_random_traffic(250);
    wait_idle();

    // Extreme heads, timeout of one tick: one tick aborts mid-frame
    write_reg(REG_HEAD_DEVICE, 32'h00);
    write_reg(REG_HEAD_FORWARD, 32'hFF);
    write_reg(REG_BYTE_TIMEOUT, 32'd1);
    n_settings++;
    push_tick();
    push_byte(8'h00);
    push_byte(8'h42);
    push_tick();
    queue_frame(8'hFF, 8'h42, 8'h7E, 8'd1, 1'b1, 0);
    queue_random_traffic(250);
    wait_idle();

    // Both heads equal, longest timeout, one maximum-length frame
    write_reg(REG_HEAD_DEVICE, 32'h5A);
    write_reg(REG_HEAD_FORWARD, 32'h5A);
    write_reg(REG_BYTE_TIMEOUT, 32'hFFFF);
    n_settings++;
    queue_frame(8'h5A, 8'h33, 8'h01, 8'd3, 1'b1, 6);
    queue_frame(8'h5A, 8'h34, 8'h02, 8'd255, 1'b1, 6);
    queue_random_traffic(100);
    wait_idle();

    // Zero timeout: any tick inside a frame aborts it
    write_reg(REG_BYTE_TIMEOUT, 32'd0);
    n_settings++;
    push_byte(8'h5A);
    push_tick();
    queue_frame(8'h5A, 8'h10, 8'h20, 8'd1, 1'b1, 0);
    push_tick();
    queue_random_traffic(100);
    wait_idle();

    write_reg(REG_HEAD_DEVICE, 32'($urandom_range(0, 255)));
    write_reg(REG_HEAD_FORWARD, 32'($urandom_range(0, 255)));
    write_reg(REG_BYTE_TIMEOUT, 32'($urandom_range(2, 30)));
    n_settings++;
    queue_random_traffic(300);
    wait_idle();

    $display("Sent %0d requests over %0d register settings; %0d mismatches", accepted_cnt,
             n_settings, mismatch_cnt);
    $display("Results: %0d payload bytes, %0d frame ends (%0d good CRC), %0d timeout aborts",
             n_data, n_end, n_good, n_abort);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### uart_frame_receiver_crc8_core.f
+incdir+rtl
rtl/urfc_pkg.sv
rtl/urfc_cfg_regs.sv
rtl/uart_frame_receiver_crc8_core.sv
dv/uart_frame_receiver_crc8_core_tb.sv
